/* hdl/qse_pkg.sv */
// Shared types, constants and helpers for the quadrature speed estimator.
`timescale 1ns / 1ps
`default_nettype none
package qse_pkg;
    localparam logic [1:0] REQ_PIN   = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_CLR   = 2'd2;
    localparam logic [1:0] REQ_CLR_Z = 2'd3;

    localparam logic [1:0] CFG_CPR   = 2'd0;
    localparam logic [1:0] CFG_LEN   = 2'd1;
    localparam logic [1:0] CFG_ALPHA = 2'd2;

    localparam logic signed [23:0] RPM_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] RPM_MIN = -24'sh800000;

    // Job item (tick or clear) handed from the front end to the speed engine.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] count;
        logic signed [31:0] delta;
        logic [15:0]        ms;
    } t_job;

    function automatic logic signed [1:0] step_of(input logic [3:0] code);
        case (code)
            4'd1, 4'd7, 4'd8, 4'd14: step_of = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: step_of = 2'sd1;
            default: step_of = 2'sd0;
        endcase
    endfunction
endpackage
`default_nettype wire

/* hdl/qse_divider.sv */
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module qse_divider (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_num,
    input  wire logic [33:0]        i_den,
    output logic                    o_done,
    output logic signed [63:0]      o_quo
);
    logic [63:0] r_q, n_q;
    logic [63:0] r_rem;
    logic [33:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_neg, r_busy;
    logic [64:0] w_trial;

    assign w_trial = {r_rem, r_q[63]} - {31'd0, r_den};

    always_comb begin
        n_q = {r_q[62:0], ~w_trial[64]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= !i_start && r_busy && (r_cnt == 7'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_neg  <= i_num[63];
                r_q    <= i_num[63] ? 64'(-i_num) : 64'(i_num);
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= w_trial[64] ? {r_rem[62:0], r_q[63]} : w_trial[63:0];
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_quo = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule
`default_nettype wire

/* hdl/qse_front.sv */
// Front end: pin decoding, count tracking and tick and clear packaging into the queue.
`timescale 1ns / 1ps
`default_nettype none
module qse_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic        i_pin_a,
    input  wire logic        i_pin_b,
    input  wire logic [15:0] i_elapsed_ms,
    output logic             o_push,
    output qse_pkg::t_job    o_job,
    input  wire logic        i_full
);
    logic [31:0] r_count, r_last;
    logic [1:0]  r_pins;
    logic        w_acc;
    logic [1:0]  w_s;
    logic signed [1:0] w_step;

    assign o_stall = i_full;
    assign w_acc   = i_valid && !i_full;
    assign w_s     = {i_pin_a, i_pin_b};
    assign o_push  = w_acc && (i_req_type != qse_pkg::REQ_PIN);
    assign w_step  = qse_pkg::step_of({r_pins, w_s});

    always_comb begin
        o_job.kind  = i_req_type;
        o_job.count = (i_req_type == qse_pkg::REQ_CLR_Z) ? 32'sd0 : $signed(r_count);
        o_job.delta = $signed(r_count - r_last);
        o_job.ms    = i_elapsed_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_last  <= '0;
            r_pins  <= '0;
        end else if (w_acc) begin
            case (i_req_type)
                qse_pkg::REQ_PIN: begin
                    r_count <= r_count + {{30{w_step[1]}}, w_step};
                    r_pins  <= w_s;
                end
                qse_pkg::REQ_TICK: r_last <= r_count;
                qse_pkg::REQ_CLR: r_last <= r_count;
                default: begin
                    r_count <= '0;
                    r_last  <= '0;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

/* hdl/qse_queue.sv */
// Two-entry queue between the front end and the speed engine.
`timescale 1ns / 1ps
`default_nettype none
module qse_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire qse_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_avail,
    output qse_pkg::t_job      o_job
);
    qse_pkg::t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_n;

    assign o_full  = (r_n == 2'd2);
    assign o_avail = (r_n != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_n  <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_n <= r_n + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

/* hdl/qse_back.sv */
// Speed engine: divides, ring walk for the average, filter, output register and ring clearing.
`timescale 1ns / 1ps
`default_nettype none
module qse_back #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_avail,
    input  wire qse_pkg::t_job i_job,
    output logic               o_pop,
    input  wire logic [16:0]   i_cpr,
    input  wire logic [4:0]    i_len,
    input  wire logic [8:0]    i_alpha,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic signed [31:0] o_enc_count,
    output logic signed [31:0] o_count_delta,
    output logic signed [47:0] o_shaft_angle,
    output logic signed [23:0] o_rpm_raw,
    output logic signed [23:0] o_rpm_avg,
    output logic signed [23:0] o_rpm_filtered
);
    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001, S_MUL  = 9'b000000010, S_DIVP = 9'b000000100,
        S_DIVR = 9'b000001000, S_WALK = 9'b000010000, S_DIVA = 9'b000100000,
        S_FILT = 9'b001000000, S_OUT  = 9'b010000000, S_CLR  = 9'b100000000
    } t_state;
    t_state r_st;

    logic signed [31:0] r_count, r_delta;
    logic [15:0] r_ms;
    logic [33:0] r_cprms;
    logic [16:0] r_cpr;
    logic signed [47:0] r_pos;
    logic signed [23:0] r_raw, r_avg, r_filt;
    logic signed [28:0] r_sum;
    logic signed [23:0] r_ring [RING_DEPTH];
    logic [AW-1:0] r_wpos, r_idx;
    logic [FW-1:0] r_fill, r_n, r_k;
    logic [AW:0]   r_clr;
    logic          r_dstart;
    logic signed [63:0] r_num;
    logic [33:0]   r_den;
    logic          w_done;
    logic signed [63:0] w_quo;
    logic signed [33:0] r_fsum;
    logic signed [23:0] w_sat;
    logic signed [47:0] w_psat;
    logic [FW-1:0] w_fill1, w_n;
    logic [8:0]    w_a;

    qse_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_num), .i_den(r_den), .o_done(w_done), .o_quo(w_quo)
    );

    assign w_sat = (w_quo > 64'sd8388607) ? qse_pkg::RPM_MAX :
                   (w_quo < -64'sd8388608) ? qse_pkg::RPM_MIN : w_quo[23:0];
    assign w_psat = (w_quo > 64'sh00007FFFFFFFFFFF) ? 48'sh7FFFFFFFFFFF :
                    (w_quo < -64'sh0000800000000000) ? 48'sh800000000000 : w_quo[47:0];
    assign w_a   = (i_alpha > 9'd256) ? 9'd256 : i_alpha;

    always_comb begin
        w_fill1 = (r_fill < FW'(RING_DEPTH)) ? r_fill + FW'(1) : r_fill;
        if (i_len == 5'd0) w_n = FW'(1);
        else if (32'(i_len) > RING_DEPTH) w_n = FW'(RING_DEPTH);
        else w_n = FW'(i_len);
        if (w_n > w_fill1) w_n = w_fill1;
    end

    assign o_pop = (r_st == S_IDLE) && i_avail && !(o_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLR;
            r_clr    <= '0;
            o_valid  <= 1'b0;
            r_dstart <= 1'b0;
            r_wpos   <= '0;
            r_fill   <= '0;
            r_filt   <= '0;
        end else begin
            r_dstart <= (r_st == S_MUL) || ((r_st == S_DIVP) && w_done)
                     || ((r_st == S_WALK) && (r_k == r_n));
            if ((r_st == S_OUT) && (!o_valid || !i_stall)) o_valid <= 1'b1;
            else if (o_valid && !i_stall) o_valid <= 1'b0;
            case (r_st)
                S_IDLE: if (o_pop) begin
                    if (i_job.kind == qse_pkg::REQ_TICK) begin
                        r_count <= i_job.count;
                        r_delta <= i_job.delta;
                        r_ms    <= (i_job.ms == 16'd0) ? 16'd1 : i_job.ms;
                        r_cpr   <= (i_cpr == 17'd0) ? 17'd1 : i_cpr;
                        r_st    <= S_MUL;
                    end else begin
                        r_clr <= '0;
                        r_st  <= S_CLR;
                    end
                end
                S_CLR: begin
                    r_ring[r_clr[AW-1:0]] <= '0;
                    r_wpos <= '0;
                    r_fill <= '0;
                    r_filt <= '0;
                    r_clr  <= r_clr + 1'b1;
                    if (32'(r_clr) == RING_DEPTH - 1) r_st <= S_IDLE;
                end
                S_MUL: begin
                    r_cprms  <= 34'(r_cpr * r_ms);
                    r_num    <= 64'(r_count) * 64'sd92160;
                    r_den    <= {17'd0, r_cpr};
                    r_st     <= S_DIVP;
                end
                S_DIVP: if (w_done) begin
                    r_pos <= w_psat;
                    r_num <= 64'(r_delta) * 64'sd15360000;
                    r_den <= r_cprms;
                    r_st  <= S_DIVR;
                end
                S_DIVR: if (w_done) begin
                    r_raw  <= w_sat;
                    r_ring[r_wpos] <= w_sat;
                    r_wpos <= (32'(r_wpos) == RING_DEPTH - 1) ? '0 : r_wpos + 1'b1;
                    r_idx  <= r_wpos;
                    r_fill <= w_fill1;
                    r_n    <= w_n;
                    r_k    <= '0;
                    r_sum  <= '0;
                    r_st   <= S_WALK;
                end
                S_WALK: begin
                    // Newest entry comes from the fresh raw value; older ones from the ring.
                    if (r_k == r_n) begin
                        r_num <= 64'(r_sum);
                        r_den <= 34'(r_n);
                        r_st  <= S_DIVA;
                    end else begin
                        r_sum <= r_sum + 29'((r_k == '0) ? r_raw : r_ring[r_idx]);
                        r_idx <= (r_idx == '0) ? AW'(RING_DEPTH - 1) : r_idx - 1'b1;
                        r_k   <= r_k + 1'b1;
                    end
                end
                S_DIVA: if (w_done) begin
                    r_avg  <= w_quo[23:0];
                    r_fsum <= $signed({25'd0, w_a}) * 34'($signed(w_quo[23:0]))
                            + $signed({25'd0, 9'd256 - w_a}) * 34'(r_filt);
                    r_st   <= S_FILT;
                end
                S_FILT: begin
                    r_filt <= r_fsum[31:8];
                    r_st   <= S_OUT;
                end
                S_OUT: if (!o_valid || !i_stall) begin
                    o_enc_count    <= r_count;
                    o_count_delta  <= r_delta;
                    o_shaft_angle  <= r_pos;
                    o_rpm_raw      <= r_raw;
                    o_rpm_avg      <= r_avg;
                    o_rpm_filtered <= r_filt;
                    r_st           <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hdl/quadrature_speed_estimator.sv */
// Top level: quadrature decoder front end, queue and speed engine.
// Pin updates stay in the front end; a sample tick runs, from acceptance to result, three
// 64-step divides in one shared divider plus an N-step ring walk.
// Clears sweep the ring. After the synchronous reset a clearing pass over the ring
// runs before ticks are processed.
`timescale 1ns / 1ps
`default_nettype none
module quadrature_speed_estimator #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic        i_pin_a,
    input  wire logic        i_pin_b,
    input  wire logic [15:0] i_elapsed_ms,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [31:0] o_enc_count,
    output logic signed [31:0] o_count_delta,
    output logic signed [47:0] o_shaft_angle,
    output logic signed [23:0] o_rpm_raw,
    output logic signed [23:0] o_rpm_avg,
    output logic signed [23:0] o_rpm_filtered
);
    logic [16:0] r_cpr;
    logic [4:0]  r_len;
    logic [8:0]  r_alpha;
    logic push, full, pop, avail;
    qse_pkg::t_job job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr   <= 17'd600;
            r_len   <= 5'd8;
            r_alpha <= 9'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                qse_pkg::CFG_CPR:   r_cpr   <= i_cfg_data;
                qse_pkg::CFG_LEN:   r_len   <= i_cfg_data[4:0];
                qse_pkg::CFG_ALPHA: r_alpha <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    qse_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_pin_a(i_pin_a), .i_pin_b(i_pin_b),
        .i_elapsed_ms(i_elapsed_ms), .o_push(push), .o_job(job_in), .i_full(full)
    );

    qse_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(job_in),
        .o_full(full), .i_pop(pop), .o_avail(avail), .o_job(job_out)
    );

    qse_back #(.RING_DEPTH(RING_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(avail), .i_job(job_out),
        .o_pop(pop), .i_cpr(r_cpr), .i_len(r_len), .i_alpha(r_alpha),
        .o_valid(o_valid), .i_stall(i_stall), .o_enc_count(o_enc_count),
        .o_count_delta(o_count_delta), .o_shaft_angle(o_shaft_angle),
        .o_rpm_raw(o_rpm_raw), .o_rpm_avg(o_rpm_avg), .o_rpm_filtered(o_rpm_filtered)
    );
endmodule
`default_nettype wire

/* hdl/qse_checker.sv */
// Port-level checker for the quadrature speed estimator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module qse_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_stall,
    input wire logic signed [31:0] o_enc_count,
    input wire logic signed [23:0] o_rpm_raw
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rpm_raw) && $stable(o_enc_count))
        else $error("result dropped under stall");
    a_rst_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall) else $error("stall after reset");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid) else $error("results too close");
endmodule

bind quadrature_speed_estimator qse_checker u_qse_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_stall(o_stall), .o_enc_count(o_enc_count), .o_rpm_raw(o_rpm_raw)
);
`default_nettype wire

/* test/quadrature_speed_estimator_test.sv */
// Self-checking testbench for the quadrature speed estimator.
`timescale 1ns / 1ps
`default_nettype none

// Predicts tick results and compares them with what the block delivers.
class speed_scoreboard;
    int unsigned cpr_reg;
    int unsigned len_reg;
    int unsigned alpha_reg;
    bit [31:0] count_now;
    bit [1:0]  last_pins;
    bit [31:0] count_prev_tick;
    longint    history[16];
    int unsigned hist_ptr;
    int unsigned hist_fill;
    longint    smooth;
    int unsigned errors;
    int unsigned ticks_seen;

    typedef struct {
        bit signed [31:0] enc;
        bit signed [31:0] dlt;
        bit signed [47:0] pos;
        bit signed [23:0] raw;
        bit signed [23:0] avg;
        bit signed [23:0] filt;
    } t_speed_rec;

    t_speed_rec pending[$];

    function new();
        cpr_reg = 600;
        len_reg = 8;
        alpha_reg = 64;
        count_now = 0;
        last_pins = 0;
        errors = 0;
        ticks_seen = 0;
        wipe_history();
    endfunction

    function void wipe_history();
        count_prev_tick = count_now;
        foreach (history[i]) history[i] = 0;
        hist_ptr = 0;
        hist_fill = 0;
        smooth = 0;
    endfunction

    function void set_reg(bit [1:0] idx, bit [16:0] val);
        case (idx)
            qse_pkg::CFG_CPR:   cpr_reg = val;
            qse_pkg::CFG_LEN:   len_reg = val[4:0];
            qse_pkg::CFG_ALPHA: alpha_reg = val[8:0];
            default: ;
        endcase
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void note_request(bit [1:0] kind, bit a, bit b, bit [15:0] ms_in);
        bit [1:0] pins;
        bit [3:0] code;
        longint cpr, ms, pos, raw, total, avg, filt, mix;
        int unsigned n, al;
        bit signed [31:0] enc, dlt;
        t_speed_rec r;
        case (kind)
            qse_pkg::REQ_PIN: begin
                pins = {a, b};
                code = {last_pins, pins};
                // Forward steps follow 0-2-3-1, reverse the opposite order.
                if (code inside {4'd2, 4'd4, 4'd11, 4'd13}) count_now += 1;
                else if (code inside {4'd1, 4'd7, 4'd8, 4'd14}) count_now -= 1;
                last_pins = pins;
            end
            qse_pkg::REQ_CLR: wipe_history();
            qse_pkg::REQ_CLR_Z: begin
                count_now = 0;
                wipe_history();
            end
            default: begin
                cpr = (cpr_reg == 0) ? 1 : cpr_reg;
                ms = (ms_in == 0) ? 1 : ms_in;
                enc = count_now;
                dlt = count_now - count_prev_tick;
                count_prev_tick = count_now;
                pos = clip((longint'(enc) * 92160) / cpr, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
                raw = clip((longint'(dlt) * 15360000) / (cpr * ms), -8388608, 8388607);
                history[hist_ptr] = raw;
                hist_ptr = (hist_ptr + 1) % 16;
                if (hist_fill < 16) hist_fill++;
                n = (len_reg == 0) ? 1 : len_reg;
                if (n > 16) n = 16;
                if (n > hist_fill) n = hist_fill;
                total = 0;
                for (int k = 0; k < n; k++) total += history[(hist_ptr + 15 - k) % 16];
                avg = clip(total / longint'(n), -8388608, 8388607);
                al = (alpha_reg > 256) ? 256 : alpha_reg;
                mix = longint'(al) * avg + longint'(256 - al) * smooth;
                filt = (mix >= 0) ? mix / 256 : -((-mix + 255) / 256);
                filt = clip(filt, -8388608, 8388607);
                smooth = filt;
                r.enc = enc;
                r.dlt = dlt;
                r.pos = 48'(pos);
                r.raw = 24'(raw);
                r.avg = 24'(avg);
                r.filt = 24'(filt);
                pending.push_back(r);
            end
        endcase
    endfunction

    function void report(string what, longint got, longint want);
        $display("error: %s got %0d, wanted %0d", what, got, want);
        errors++;
    endfunction

    function void check_result(bit signed [31:0] enc, bit signed [31:0] dlt,
                               bit signed [47:0] pos, bit signed [23:0] raw,
                               bit signed [23:0] avg, bit signed [23:0] filt);
        t_speed_rec w;
        ticks_seen++;
        if (pending.size() == 0) begin
            report("result count with no tick outstanding", ticks_seen, ticks_seen - 1);
            return;
        end
        w = pending.pop_front();
        if (enc !== w.enc) report("enc_count", enc, w.enc);
        if (dlt !== w.dlt) report("count_delta", dlt, w.dlt);
        if (pos !== w.pos) report("shaft_angle", pos, w.pos);
        if (raw !== w.raw) report("rpm_raw", raw, w.raw);
        if (avg !== w.avg) report("rpm_avg", avg, w.avg);
        if (filt !== w.filt) report("rpm_filtered", filt, w.filt);
    endfunction
endclass

module quadrature_speed_estimator_test;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type = qse_pkg::REQ_PIN;
    logic        i_pin_a = 1'b0;
    logic        i_pin_b = 1'b0;
    logic [15:0] i_elapsed_ms = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = qse_pkg::CFG_CPR;
    logic [16:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_enc_count;
    logic signed [31:0] o_count_delta;
    logic signed [47:0] o_shaft_angle;
    logic signed [23:0] o_rpm_raw;
    logic signed [23:0] o_rpm_avg;
    logic signed [23:0] o_rpm_filtered;

    speed_scoreboard board = new();
    bit calm_phase = 0;
    bit hold_receiver = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sent_items = 0;
    bit [1:0] pin_state = 2'b00;

    quadrature_speed_estimator dut (.*);

    always #1 i_clk = ~i_clk;

    // Result side: random stalls, an optional long hold-off, and the checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_enc_count, o_count_delta, o_shaft_angle,
                               o_rpm_raw, o_rpm_avg, o_rpm_filtered);
    end

    initial begin : stall_gen
        int burst;
        forever begin
            @(posedge i_clk);
            if (hold_receiver) begin
                i_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
                hold_receiver = 0;
                i_stall <= 1'b0;
            end else if (!calm_phase && $urandom_range(3) == 0) begin
                burst = $urandom_range(1, 5);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Valid stays high after acceptance so the next transaction can follow at once.
    task automatic send(bit [1:0] kind, bit a, bit b, bit [15:0] ms);
        if (!calm_phase && $urandom_range(4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= kind;
        i_pin_a <= a;
        i_pin_b <= b;
        i_elapsed_ms <= ms;
        do @(posedge i_clk); while (o_stall);
        board.note_request(kind, a, b, ms);
        sent_items++;
    endtask

    // Moves the encoder one step forward or back along the Gray sequence.
    task automatic turn(bit forward);
        bit [1:0] nxt;
        case (pin_state)
            2'b00: nxt = forward ? 2'b10 : 2'b01;
            2'b10: nxt = forward ? 2'b11 : 2'b00;
            2'b11: nxt = forward ? 2'b01 : 2'b10;
            default: nxt = forward ? 2'b00 : 2'b11;
        endcase
        pin_state = nxt;
        send(qse_pkg::REQ_PIN, nxt[1], nxt[0], 16'd0);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(bit [1:0] idx, bit [16:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic random_item();
        int pick;
        bit [1:0] p;
        pick = $urandom_range(99);
        if (pick < 60) begin
            turn($urandom_range(99) < 70);
        end else if (pick < 68) begin
            p = 2'($urandom);
            pin_state = p;
            send(qse_pkg::REQ_PIN, p[1], p[0], 16'd0);
        end else if (pick < 94) begin
            send(qse_pkg::REQ_TICK, 1'b0, 1'b0,
                 ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20)));
        end else begin
            send(($urandom_range(1) == 0) ? qse_pkg::REQ_CLR : qse_pkg::REQ_CLR_Z,
                 1'($urandom), 1'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (40) @(posedge i_clk);

        // Directed: steps both ways, illegal jumps, clears, extreme fields.
        send(qse_pkg::REQ_TICK, 1'b0, 1'b0, 16'd0);
        repeat (4) turn(1'b1);
        send(qse_pkg::REQ_PIN, 1'b1, 1'b1, 16'hFFFF);
        pin_state = 2'b11;
        send(qse_pkg::REQ_TICK, 1'b1, 1'b1, 16'd1);
        repeat (3) turn(1'b0);
        send(qse_pkg::REQ_TICK, 1'b0, 1'b0, 16'hFFFF);
        send(qse_pkg::REQ_CLR, 1'b0, 1'b0, 16'd0);
        turn(1'b1);
        send(qse_pkg::REQ_TICK, 1'b0, 1'b0, 16'd5);
        send(qse_pkg::REQ_CLR_Z, 1'b1, 1'b1, 16'hFFFF);
        send(qse_pkg::REQ_TICK, 1'b0, 1'b0, 16'd1);
        drain();

        // Setting sweep: extremes, out-of-range values, random picks and the defaults of every register.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(qse_pkg::CFG_CPR, 17'd1);
                          write_reg(qse_pkg::CFG_LEN, 17'd1);
                          write_reg(qse_pkg::CFG_ALPHA, 17'd256); end
                1: begin write_reg(qse_pkg::CFG_CPR, 17'd100000);
                          write_reg(qse_pkg::CFG_LEN, 17'd16);
                          write_reg(qse_pkg::CFG_ALPHA, 17'd0); end
                2: begin write_reg(qse_pkg::CFG_CPR, 17'd0);
                          write_reg(qse_pkg::CFG_LEN, 17'd0);
                          write_reg(qse_pkg::CFG_ALPHA, 17'h1FF); end
                3: begin write_reg(qse_pkg::CFG_CPR, 17'h1FFFF);
                          write_reg(qse_pkg::CFG_LEN, 17'h1F);
                          write_reg(qse_pkg::CFG_ALPHA, 17'd300); end
                4: begin write_reg(qse_pkg::CFG_CPR, 17'($urandom_range(1, 4000)));
                          write_reg(qse_pkg::CFG_LEN, 17'($urandom_range(1, 16)));
                          write_reg(qse_pkg::CFG_ALPHA, 17'($urandom_range(0, 256))); end
                default: begin write_reg(qse_pkg::CFG_CPR, 17'd600);
                          write_reg(qse_pkg::CFG_LEN, 17'd8);
                          write_reg(qse_pkg::CFG_ALPHA, 17'd64); end
            endcase
            if (phase == 1) hold_receiver = 1;
            if (phase == 5) calm_phase = 1;
            for (int k = 0; k < 100; k++) random_item();
            drain();
        end

        $display("covered %0d transactions and %0d checked ticks across six register settings",
                 sent_items, board.ticks_seen);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
hdl/qse_pkg.sv
hdl/qse_divider.sv
hdl/qse_front.sv
hdl/qse_queue.sv
hdl/qse_back.sv
hdl/quadrature_speed_estimator.sv
hdl/qse_checker.sv
test/quadrature_speed_estimator_test.sv
